// ===== rtl/mma_pkg.sv =====
package mma_pkg;

  // Fixed widths of the item fields and configuration registers.
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ValW     = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned DimW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RESULT_ROWS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESULT_COLS  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACCUMULATE   = 2'd3;

  // Reset values of the dimension registers.
  localparam logic [DimW-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL_LL,
    ST_MUL_HL,
    ST_MUL_LH,
    ST_ACC,
    ST_CSUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e                    op;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_row;
    logic [IdxW-1:0]        out_col;
    logic signed [ValW-1:0] out_value;
    logic                   last;
  } out_item_t;

endpackage

// ===== rtl/mma_store.sv =====
module mma_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [mma_pkg::ValW-1:0]     wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [mma_pkg::ValW-1:0]     rdata_o
);

  logic [mma_pkg::ValW-1:0] mem [DEPTH];
  logic [mma_pkg::ValW-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/matrix_multiply_accumulate.sv =====
// Integer matrix multiply with optional accumulation into C.
// Input words arrive on in_valid_i/in_ready_o. A load word (A, B or C) writes one
// 64-bit entry at its row and column and leaves the block ready; loads outside MAX_DIM
// are dropped. A compute word makes the block emit every result entry in
// row-major order on out_valid_o/out_ready_i, with last set on the final one.
// Each result is also written back into the C store.
// One shared 32x32 multiplier builds each 64-bit product from three partial
// products, so each multiply-add steps through operand fetch, the three partial
// products and a last add. One result entry runs those steps once per unit of
// inner_length, then a C add and an emit step, and a compute word repeats that
// for each of its result_rows * result_cols entries.
// in_ready_o is high only while the sequencer is idle.
// The result register decouples the two sides: when the receiver stalls, the
// sequencer holds at the emit step until the register is free, and loads are
// taken while a final result waits to be taken.
// Reset sets the dimensions to 8, turns accumulation off, clears the accumulator
// and empties the result register. Store contents are undefined until written;
// there is no clearing pass. Configuration writes take effect at once and belong
// in idle periods.
module matrix_multiply_accumulate #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mma_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mma_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mma_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mma_pkg::out_item_t               out_item_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = mma_pkg::IdxW;
  localparam int unsigned DW    = mma_pkg::DimW;
  localparam int unsigned VW    = mma_pkg::ValW;
  localparam int unsigned HW    = mma_pkg::HalfW;
  localparam logic [DW-1:0] MaxDim = DW'(MAX_DIM);

  // Row-major entry address.
  function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
    logic [2*IW:0] full;
    full = (2*IW+1)'(r) * (2*IW+1)'(MAX_DIM) + (2*IW+1)'(c);
    return full[AW-1:0];
  endfunction

  logic [DW-1:0] rows_q, inner_q, cols_q;
  logic          acc_en_q;

  mma_pkg::state_e state_q, state_d;
  logic [IW-1:0]   i_q, i_d, j_q, j_d, l_q, l_d;
  logic [VW-1:0]   acc_q, acc_d, add_b;
  logic [VW-1:0]   prod_q, prod_d;
  logic [HW-1:0]   mul_a, mul_b;
  logic [VW-1:0]   a_rd, b_rd, c_rd;

  logic               out_valid_q, out_valid_d;
  mma_pkg::out_item_t out_q, out_d;

  logic [DW-1:0] rows_lim, inner_lim, cols_lim;
  logic          in_fire, in_range, emit_fire, last_entry, row_end, inner_end;
  logic          a_we, b_we, c_we;
  logic [AW-1:0] ld_addr, c_waddr;
  logic [VW-1:0] c_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= mma_pkg::DIM_RESET;
      inner_q  <= mma_pkg::DIM_RESET;
      cols_q   <= mma_pkg::DIM_RESET;
      acc_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mma_pkg::CFG_RESULT_ROWS:  rows_q   <= cfg_data_i[DW-1:0];
        mma_pkg::CFG_INNER_LENGTH: inner_q  <= cfg_data_i[DW-1:0];
        mma_pkg::CFG_RESULT_COLS:  cols_q   <= cfg_data_i[DW-1:0];
        mma_pkg::CFG_ACCUMULATE:   acc_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Dimensions above MAX_DIM saturate.
  assign rows_lim  = (rows_q  > MaxDim) ? MaxDim : rows_q;
  assign inner_lim = (inner_q > MaxDim) ? MaxDim : inner_q;
  assign cols_lim  = (cols_q  > MaxDim) ? MaxDim : cols_q;

  assign in_ready_o = (state_q == mma_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, in_item_i.row} < MaxDim) && ({1'b0, in_item_i.col} < MaxDim);
  assign ld_addr    = addr_of(in_item_i.row, in_item_i.col);

  assign row_end    = ({1'b0, j_q} + DW'(1)) == cols_lim;
  assign last_entry = (({1'b0, i_q} + DW'(1)) == rows_lim) && row_end;
  assign inner_end  = ({1'b0, l_q} + DW'(1)) == inner_lim;
  assign emit_fire  = (state_q == mma_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  // Store write ports; C is shared between loads and result write-back.
  assign a_we    = in_fire && in_range && (in_item_i.op == mma_pkg::OP_LOAD_A);
  assign b_we    = in_fire && in_range && (in_item_i.op == mma_pkg::OP_LOAD_B);
  assign c_we    = emit_fire ||
                   (in_fire && in_range && (in_item_i.op == mma_pkg::OP_LOAD_C));
  assign c_waddr = emit_fire ? addr_of(i_q, j_q) : ld_addr;
  assign c_wdata = emit_fire ? acc_q : VW'(in_item_i.value);

  mma_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (VW'(in_item_i.value)),
    .raddr_i (addr_of(i_q, l_q)),
    .rdata_o (a_rd)
  );

  mma_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (ld_addr),
    .wdata_i (VW'(in_item_i.value)),
    .raddr_i (addr_of(l_q, j_q)),
    .rdata_o (b_rd)
  );

  mma_store #(.DEPTH(DEPTH), .AW(AW)) u_store_c (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (addr_of(i_q, j_q)),
    .rdata_o (c_rd)
  );

  // Shared multiplier and accumulator adder.
  assign prod_d = VW'(mul_a) * VW'(mul_b);
  assign acc_d  = acc_q + add_b;

  // Sequencer: next state, counters and operand selection.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    l_d         = l_q;
    mul_a       = a_rd[HW-1:0];
    mul_b       = b_rd[HW-1:0];
    add_b       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      mma_pkg::ST_IDLE: begin
        if (in_fire && (in_item_i.op == mma_pkg::OP_COMPUTE) &&
            (rows_lim != '0) && (cols_lim != '0)) begin
          i_d     = '0;
          j_d     = '0;
          l_d     = '0;
          add_b   = -acc_q;
          state_d = mma_pkg::ST_FETCH;
        end
      end
      mma_pkg::ST_FETCH: begin
        state_d = (inner_lim == '0) ? mma_pkg::ST_CSUM : mma_pkg::ST_MUL_LL;
      end
      mma_pkg::ST_MUL_LL: begin
        state_d = mma_pkg::ST_MUL_HL;
      end
      mma_pkg::ST_MUL_HL: begin
        mul_a   = a_rd[VW-1:HW];
        add_b   = prod_q;
        state_d = mma_pkg::ST_MUL_LH;
      end
      mma_pkg::ST_MUL_LH: begin
        mul_b   = b_rd[VW-1:HW];
        add_b   = {prod_q[HW-1:0], {HW{1'b0}}};
        state_d = mma_pkg::ST_ACC;
      end
      mma_pkg::ST_ACC: begin
        add_b = {prod_q[HW-1:0], {HW{1'b0}}};
        if (inner_end) begin
          l_d     = '0;
          state_d = mma_pkg::ST_CSUM;
        end else begin
          l_d     = l_q + IW'(1);
          state_d = mma_pkg::ST_FETCH;
        end
      end
      mma_pkg::ST_CSUM: begin
        add_b   = acc_en_q ? c_rd : '0;
        state_d = mma_pkg::ST_EMIT;
      end
      mma_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d       = 1'b1;
          out_d.out_row     = i_q;
          out_d.out_col     = j_q;
          out_d.out_value   = acc_q;
          out_d.last        = last_entry;
          add_b             = -acc_q;
          if (last_entry) begin
            state_d = mma_pkg::ST_IDLE;
          end else begin
            if (row_end) begin
              j_d = '0;
              i_d = i_q + IW'(1);
            end else begin
              j_d = j_q + IW'(1);
            end
            state_d = mma_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_d = mma_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mma_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      l_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      l_q         <= l_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/mma_checker.sv =====
module mma_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input mma_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mma_pkg::out_item_t out_item_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result word changed while stalled");

  // A pending result that is not the last one means a compute is still running.
  a_busy_mid_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !in_ready_o)
    else $error("input taken in the middle of a result matrix");

  // A load word leaves the block ready for the next word.
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op != mma_pkg::OP_COMPUTE) |=> in_ready_o)
    else $error("load word stalled the input");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== bench/mma_result_checker.sv =====
`timescale 1ns / 1ps
module mma_result_checker #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mma_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mma_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  mma_pkg::in_item_t            in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  mma_pkg::out_item_t           out_item_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  // Private copy of the three operand stores and the dimension registers.
  logic [mma_pkg::ValW-1:0] a_mem [MAX_DIM][MAX_DIM];
  logic [mma_pkg::ValW-1:0] b_mem [MAX_DIM][MAX_DIM];
  logic [mma_pkg::ValW-1:0] c_mem [MAX_DIM][MAX_DIM];
  logic [mma_pkg::DimW-1:0] rows_q;
  logic [mma_pkg::DimW-1:0] inner_q;
  logic [mma_pkg::DimW-1:0] cols_q;
  logic                     acc_q;

  // Result entries still owed by the block, oldest first.
  mma_pkg::out_item_t sums_due [$];
  mma_pkg::out_item_t want;
  int unsigned        fails;

  // Dimensions above the store size saturate.
  function automatic int unsigned clip_dim(logic [mma_pkg::DimW-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Work out every result entry of one compute word and write it back into C.
  task automatic multiply_into_c();
    int unsigned              n_rows;
    int unsigned              n_inner;
    int unsigned              n_cols;
    int unsigned              i;
    int unsigned              j;
    int unsigned              l;
    logic [mma_pkg::ValW-1:0] sum;
    mma_pkg::out_item_t       res;
    n_rows  = clip_dim(rows_q);
    n_inner = clip_dim(inner_q);
    n_cols  = clip_dim(cols_q);
    for (i = 0; i < n_rows; i++) begin
      for (j = 0; j < n_cols; j++) begin
        sum = '0;
        for (l = 0; l < n_inner; l++) begin
          sum = sum + a_mem[i][l] * b_mem[l][j];
        end
        if (acc_q) begin
          sum = sum + c_mem[i][j];
        end
        c_mem[i][j]   = sum;
        res.out_row   = mma_pkg::IdxW'(i);
        res.out_col   = mma_pkg::IdxW'(j);
        res.out_value = sum;
        res.last      = (i + 1 == n_rows) && (j + 1 == n_cols);
        sums_due.push_back(res);
      end
    end
  endtask

  task automatic check_field(string field, logic [mma_pkg::ValW-1:0] exp_val,
                             logic [mma_pkg::ValW-1:0] got);
    if (exp_val !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field, exp_val, got);
      fails++;
    end
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  = mma_pkg::DIM_RESET;
      inner_q = mma_pkg::DIM_RESET;
      cols_q  = mma_pkg::DIM_RESET;
      acc_q   = 1'b0;
      sums_due.delete();
      fails   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mma_pkg::CFG_RESULT_ROWS:  rows_q  = cfg_data_i;
          mma_pkg::CFG_INNER_LENGTH: inner_q = cfg_data_i;
          mma_pkg::CFG_RESULT_COLS:  cols_q  = cfg_data_i;
          mma_pkg::CFG_ACCUMULATE:   acc_q   = cfg_data_i[0];
          default: ;
        endcase
      end

      // Compare a taken result word with the oldest entry owed.
      if (out_valid_i && out_ready_i) begin
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d value %h last %0b", $time,
                   out_item_i.out_row, out_item_i.out_col, out_item_i.out_value,
                   out_item_i.last);
          fails++;
        end else begin
          want = sums_due.pop_front();
          check_field("out_row", mma_pkg::ValW'(want.out_row),
                      mma_pkg::ValW'(out_item_i.out_row));
          check_field("out_col", mma_pkg::ValW'(want.out_col),
                      mma_pkg::ValW'(out_item_i.out_col));
          check_field("out_value", want.out_value, out_item_i.out_value);
          check_field("last", mma_pkg::ValW'(want.last), mma_pkg::ValW'(out_item_i.last));
        end
      end

      // Apply a taken input word to the private stores.
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.op == mma_pkg::OP_COMPUTE) begin
          multiply_into_c();
        end else if (in_item_i.row < MAX_DIM && in_item_i.col < MAX_DIM) begin
          case (in_item_i.op)
            mma_pkg::OP_LOAD_A: a_mem[in_item_i.row][in_item_i.col] = in_item_i.value;
            mma_pkg::OP_LOAD_B: b_mem[in_item_i.row][in_item_i.col] = in_item_i.value;
            mma_pkg::OP_LOAD_C: c_mem[in_item_i.row][in_item_i.col] = in_item_i.value;
            default: ;
          endcase
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= sums_due.size();
  end

endmodule

// ===== bench/matrix_multiply_accumulate_test.sv =====
`timescale 1ns / 1ps
module matrix_multiply_accumulate_test;

  localparam int unsigned MaxDim        = 8;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned CycleLimit    = 10_000_000;
  localparam int unsigned WordsPerPhase = 20;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned VW            = mma_pkg::ValW;

  localparam logic [VW-1:0] MaxVal  = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] MinVal  = {1'b1, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0] AllOnes = '1;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [mma_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [mma_pkg::CfgDataW-1:0] cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  mma_pkg::in_item_t            in_item_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  mma_pkg::out_item_t           out_item_o;

  int unsigned fail_count;
  int unsigned pending_sums;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;

  // Which entries hold data, so that no compute reads an unwritten entry.
  bit a_set [MaxDim][MaxDim];
  bit b_set [MaxDim][MaxDim];
  bit c_set [MaxDim][MaxDim];

  // Register values as last written.
  logic [mma_pkg::DimW-1:0] rows_cfg;
  logic [mma_pkg::DimW-1:0] inner_cfg;
  logic [mma_pkg::DimW-1:0] cols_cfg;
  logic                     acc_cfg;

  matrix_multiply_accumulate #(
    .MAX_DIM(MaxDim)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  mma_result_checker #(
    .MAX_DIM(MaxDim)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_sums)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at random with the current percentage.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL matrix_multiply_accumulate");
      $finish;
    end
  end

  function automatic int unsigned clip_dim(logic [mma_pkg::DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : int'(d);
  endfunction

  // Entry values lean toward the corners of the signed range.
  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(7))
      0: return '0;
      1: return VW'(1);
      2: return AllOnes;
      3: return MaxVal;
      4: return MinVal;
      5: return VW'($urandom_range(15)) - VW'(8);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one word after a random gap and hold it until taken.
  task automatic send_word(mma_pkg::in_item_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic load_entry(mma_pkg::op_e op, int unsigned r, int unsigned c,
                            logic [VW-1:0] v);
    mma_pkg::in_item_t w;
    w.op    = op;
    w.row   = mma_pkg::IdxW'(r);
    w.col   = mma_pkg::IdxW'(c);
    w.value = v;
    send_word(w);
    case (op)
      mma_pkg::OP_LOAD_A: a_set[r][c] = 1'b1;
      mma_pkg::OP_LOAD_B: b_set[r][c] = 1'b1;
      mma_pkg::OP_LOAD_C: c_set[r][c] = 1'b1;
      default: ;
    endcase
  endtask

  // Load whatever the next compute would read unwritten, then send the compute word.
  task automatic compute_product();
    int unsigned       n_rows;
    int unsigned       n_inner;
    int unsigned       n_cols;
    int unsigned       i;
    int unsigned       j;
    mma_pkg::in_item_t w;
    n_rows  = clip_dim(rows_cfg);
    n_inner = clip_dim(inner_cfg);
    n_cols  = clip_dim(cols_cfg);
    for (i = 0; i < n_rows; i++) begin
      for (j = 0; j < n_inner; j++) begin
        if (!a_set[i][j]) load_entry(mma_pkg::OP_LOAD_A, i, j, rand_value());
      end
    end
    for (i = 0; i < n_inner; i++) begin
      for (j = 0; j < n_cols; j++) begin
        if (!b_set[i][j]) load_entry(mma_pkg::OP_LOAD_B, i, j, rand_value());
      end
    end
    if (acc_cfg) begin
      for (i = 0; i < n_rows; i++) begin
        for (j = 0; j < n_cols; j++) begin
          if (!c_set[i][j]) load_entry(mma_pkg::OP_LOAD_C, i, j, rand_value());
        end
      end
    end
    // Index and value fields are don't-care on a compute word.
    w.op    = mma_pkg::OP_COMPUTE;
    w.row   = mma_pkg::IdxW'($urandom);
    w.col   = mma_pkg::IdxW'($urandom);
    w.value = {$urandom, $urandom};
    send_word(w);
    for (i = 0; i < n_rows; i++) begin
      for (j = 0; j < n_cols; j++) begin
        c_set[i][j] = 1'b1;
      end
    end
  endtask

  // Drop valid and wait until every result is in and the block is idle again.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_sums != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mma_pkg::CfgIdxW-1:0] idx,
                           logic [mma_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Write all four registers; the unused bits of the accumulate word are random.
  task automatic set_config(logic [mma_pkg::DimW-1:0] n_rows,
                            logic [mma_pkg::DimW-1:0] n_inner,
                            logic [mma_pkg::DimW-1:0] n_cols, logic acc);
    write_reg(mma_pkg::CFG_RESULT_ROWS, n_rows);
    write_reg(mma_pkg::CFG_INNER_LENGTH, n_inner);
    write_reg(mma_pkg::CFG_RESULT_COLS, n_cols);
    write_reg(mma_pkg::CFG_ACCUMULATE, mma_pkg::CfgDataW'({$urandom, acc}));
    cfg_we_i  <= 1'b0;
    rows_cfg  = n_rows;
    inner_cfg = n_inner;
    cols_cfg  = n_cols;
    acc_cfg   = acc;
  endtask

  initial begin
    int unsigned              phase;
    int unsigned              goal;
    int unsigned              n_loads;
    int unsigned              r_lim;
    int unsigned              c_lim;
    int unsigned              r;
    int unsigned              c;
    bit                       paused;
    mma_pkg::op_e             op;
    logic [mma_pkg::DimW-1:0] d_rows;
    logic [mma_pkg::DimW-1:0] d_inner;
    logic [mma_pkg::DimW-1:0] d_cols;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: wrap-around products, accumulation overflow and write-back.
    set_config(4'd1, 4'd1, 4'd1, 1'b0);
    load_entry(mma_pkg::OP_LOAD_A, 0, 0, MaxVal);
    load_entry(mma_pkg::OP_LOAD_B, 0, 0, MaxVal);
    compute_product();
    load_entry(mma_pkg::OP_LOAD_A, 0, 0, MinVal);
    load_entry(mma_pkg::OP_LOAD_B, 0, 0, AllOnes);
    compute_product();
    wait_idle();
    set_config(4'd1, 4'd1, 4'd1, 1'b1);
    load_entry(mma_pkg::OP_LOAD_C, 0, 0, MaxVal);
    load_entry(mma_pkg::OP_LOAD_A, 0, 0, VW'(1));
    load_entry(mma_pkg::OP_LOAD_B, 0, 0, VW'(1));
    compute_product();
    compute_product();
    // Entries at the far corner lie outside the dimensions and must be ignored.
    load_entry(mma_pkg::OP_LOAD_A, 7, 7, rand_value());
    load_entry(mma_pkg::OP_LOAD_B, 7, 7, rand_value());
    load_entry(mma_pkg::OP_LOAD_C, 7, 7, rand_value());
    compute_product();
    // Zero inner length leaves only the stored C entry.
    wait_idle();
    set_config(4'd1, 4'd0, 4'd1, 1'b1);
    compute_product();
    // Zero rows or zero columns produce no result at all.
    wait_idle();
    set_config(4'd0, 4'd1, 4'd1, 1'b0);
    compute_product();
    wait_idle();
    set_config(4'd1, 4'd1, 4'd0, 1'b0);
    compute_product();
    // Two-by-one result over an inner length of two; last flags the second word.
    wait_idle();
    set_config(4'd2, 4'd2, 4'd1, 1'b0);
    load_entry(mma_pkg::OP_LOAD_A, 0, 1, rand_value());
    load_entry(mma_pkg::OP_LOAD_A, 1, 0, rand_value());
    load_entry(mma_pkg::OP_LOAD_A, 1, 1, rand_value());
    load_entry(mma_pkg::OP_LOAD_B, 1, 0, rand_value());
    compute_product();

    // Random phases: each with its own dimensions and idling mode.
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (phase == 4) begin
        d_rows  = 4'd8;
        d_inner = 4'd8;
        d_cols  = 4'd8;
      end else if (phase == 9) begin
        // Oversized settings saturate at the store size.
        d_rows  = mma_pkg::DimW'($urandom_range(15, 9));
        d_inner = mma_pkg::DimW'($urandom_range(15, 9));
        d_cols  = mma_pkg::DimW'($urandom_range(15, 9));
      end else begin
        d_rows  = mma_pkg::DimW'($urandom_range(4, 1));
        d_inner = mma_pkg::DimW'($urandom_range(4, 1));
        d_cols  = mma_pkg::DimW'($urandom_range(4, 1));
      end
      set_config(d_rows, d_inner, d_cols, 1'($urandom));

      goal   = words_sent + WordsPerPhase;
      paused = 1'b0;
      while (words_sent < goal) begin
        n_loads = $urandom_range(6);
        repeat (n_loads) begin
          op = mma_pkg::op_e'($urandom_range(2));
          case (op)
            mma_pkg::OP_LOAD_A: begin
              r_lim = clip_dim(rows_cfg);
              c_lim = clip_dim(inner_cfg);
            end
            mma_pkg::OP_LOAD_B: begin
              r_lim = clip_dim(inner_cfg);
              c_lim = clip_dim(cols_cfg);
            end
            default: begin
              r_lim = clip_dim(rows_cfg);
              c_lim = clip_dim(cols_cfg);
            end
          endcase
          // Mostly fresh operands; now and then a stale entry anywhere.
          if ($urandom_range(3) == 0) begin
            r = $urandom_range(7);
            c = $urandom_range(7);
          end else begin
            r = $urandom_range(r_lim - 1);
            c = $urandom_range(c_lim - 1);
          end
          load_entry(op, r, c, rand_value());
        end
        compute_product();
        // Hold the sender back once until the whole result has drained.
        if (phase % 3 == 2 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS matrix_multiply_accumulate");
    end else begin
      $display("FAIL matrix_multiply_accumulate");
    end
    $finish;
  end

endmodule
